// File: rtl/msbs_pkg.sv
// shared types and constants of the multi-slot blink scheduler
// payload word types, queue command type, codes and state machine states
// no dependencies
`default_nettype none

package msbs_pkg;

  // fixed field widths
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned MASK_W   = 32;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned IVL_W    = 16;
  localparam int unsigned HALVES_W = 8;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned KIND_W   = 3;

  // register reset value
  localparam logic [IVL_W-1:0] REFRESH_RESET = 16'd1000;

  // command queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // input opcodes
  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_FLASH  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_UNDEF  = 2'd3
  } opcode_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RENDER = 3'd0,
    KIND_PAINT  = 3'd1,
    KIND_TICK   = 3'd2,
    KIND_IGNORE = 3'd3,
    KIND_CANCEL = 3'd4
  } kind_e;

  // classified commands in the queue
  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_FLASH,
    CMD_CANCEL,
    CMD_IGNORE
  } cmd_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_SUMMARY
  } back_state_e;

  // input word
  typedef struct packed {
    logic [1:0]         opcode;
    logic [TIME_W-1:0]  now_ms;
    logic [MASK_W-1:0]  tile_mask;
    logic [COLOR_W-1:0] flash_color;
    logic [COUNT_W-1:0] blink_count;
    logic [IVL_W-1:0]   blink_interval;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [MASK_W-1:0]  tiles;
    logic               show_flash;
    logic [COLOR_W-1:0] color;
    logic               job_done;
    logic               show_request;
    logic               last_item;
  } out_word_t;

  // queue entry
  typedef struct packed {
    cmd_e                cmd;
    logic [TIME_W-1:0]   now_ms;
    logic [MASK_W-1:0]   mask;
    logic [COLOR_W-1:0]  color;
    logic [HALVES_W-1:0] halves;
    logic [IVL_W-1:0]    interval;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/multi_slot_blink_scheduler.sv
// multi-slot blink scheduler top level: front end, command queue, back end
// flash, cancel and ignored words pass through the queue and the output register to the result
// a flash, cancel or ignored word is handled in the idle state; a tick is popped in the idle state,
//   then scans the slots one by one, then writes a summary, waiting for the output under out stall
// reset (rst_ni low, asynchronous): all slots free, queue empty, no result pending,
//   refresh_interval 1000, last refresh time 0
`default_nettype none

module multi_slot_blink_scheduler import msbs_pkg::*; #(
  parameter int unsigned JOB_SLOTS = 4,
  parameter int unsigned TILES     = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IVL_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_word_t         in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_word_t             out_word_o
);

  logic push, q_full, q_empty, q_pop;
  cmd_t push_cmd, head_cmd;

  // accept and classify
  msbs_front #(
    .TILES(TILES)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // decoupling queue
  msbs_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  // slot table and sequencer
  msbs_back #(
    .JOB_SLOTS(JOB_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (q_empty),
    .q_head_i    (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// File: rtl/msbs_front.sv
// front end: accepts input words, trims the tile mask and classifies the command
// depends on msbs_pkg
`default_nettype none

module msbs_front import msbs_pkg::*; #(
  parameter int unsigned TILES = 32
) (
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_word_t in_word_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  localparam logic [MASK_W-1:0] TILE_LIMIT =
    (TILES >= MASK_W) ? {MASK_W{1'b1}} : MASK_W'((64'd1 << TILES) - 64'd1);

  logic [MASK_W-1:0] mask;
  logic              empty_req;

  // hold off while the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify
  assign mask      = in_word_i.tile_mask & TILE_LIMIT;
  assign empty_req = (mask == '0) || (in_word_i.blink_count == '0);

  always_comb begin
    cmd_o.now_ms   = in_word_i.now_ms;
    cmd_o.mask     = mask;
    cmd_o.color    = in_word_i.flash_color;
    cmd_o.halves   = {in_word_i.blink_count, 1'b0};
    cmd_o.interval = in_word_i.blink_interval;
    unique case (opcode_e'(in_word_i.opcode))
      OP_TICK:   cmd_o.cmd = CMD_TICK;
      OP_FLASH:  cmd_o.cmd = empty_req ? CMD_IGNORE : CMD_FLASH;
      OP_CANCEL: cmd_o.cmd = CMD_CANCEL;
      default:   cmd_o.cmd = CMD_IGNORE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/msbs_cmd_queue.sv
// short command queue between front and back end
// depends on msbs_pkg
`default_nettype none

module msbs_cmd_queue import msbs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output cmd_t      head_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/msbs_back.sv
// back end: slot table, tick scan sequencer, refresh logic and output register
// depends on msbs_pkg
`default_nettype none

module msbs_back import msbs_pkg::*; #(
  parameter int unsigned JOB_SLOTS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IVL_W-1:0]  cfg_wdata_i,
  input  wire logic              q_empty_i,
  input  wire cmd_t              q_head_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output out_word_t              out_word_o
);

  localparam int unsigned IDX_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

  back_state_e state_q, state_d;

  // slot table
  logic [JOB_SLOTS-1:0] active_q, active_d;
  logic [MASK_W-1:0]    tiles_q    [JOB_SLOTS];
  logic [MASK_W-1:0]    tiles_d    [JOB_SLOTS];
  logic [COLOR_W-1:0]   color_q    [JOB_SLOTS];
  logic [COLOR_W-1:0]   color_d    [JOB_SLOTS];
  logic [HALVES_W-1:0]  halves_q   [JOB_SLOTS];
  logic [HALVES_W-1:0]  halves_d   [JOB_SLOTS];
  logic [JOB_SLOTS-1:0] phase_q, phase_d;
  logic [IVL_W-1:0]     interval_q [JOB_SLOTS];
  logic [IVL_W-1:0]     interval_d [JOB_SLOTS];
  logic [TIME_W-1:0]    next_q     [JOB_SLOTS];
  logic [TIME_W-1:0]    next_d     [JOB_SLOTS];

  // tick scan context
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic              dirty_q, dirty_d;
  logic [TIME_W-1:0] last_refresh_q, last_refresh_d;
  logic [IVL_W-1:0]  refresh_ivl_q;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_q, out_d;
  logic      out_free;

  // helpers
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic [TIME_W-1:0] due_diff;
  logic              due;
  logic [HALVES_W-1:0] halves_dec;
  logic [TIME_W-1:0] idle_time;
  logic              last_slot;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = JOB_SLOTS - 1; s >= 0; s--) begin
      if (!active_q[s]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(s);
      end
    end
  end

  // due test and countdown of the scanned slot
  assign due_diff   = now_q - next_q[idx_q];
  assign due        = active_q[idx_q] && !due_diff[TIME_W-1];
  assign halves_dec = (halves_q[idx_q] != '0) ? halves_q[idx_q] - 1'b1 : '0;
  assign last_slot  = (idx_q == IDX_W'(JOB_SLOTS - 1));
  assign idle_time  = now_q - last_refresh_q;

  // sequencer next state and outputs
  always_comb begin
    state_d        = state_q;
    active_d       = active_q;
    tiles_d        = tiles_q;
    color_d        = color_q;
    halves_d       = halves_q;
    phase_d        = phase_q;
    interval_d     = interval_q;
    next_d         = next_q;
    idx_d          = idx_q;
    now_d          = now_q;
    dirty_d        = dirty_q;
    last_refresh_d = last_refresh_q;
    q_pop_o        = 1'b0;
    out_valid_d    = out_valid_q && out_stall_i;
    out_d          = out_q;

    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          priority if (q_head_i.cmd == CMD_TICK) begin
            // start a scan over all slots
            q_pop_o = 1'b1;
            now_d   = q_head_i.now_ms;
            idx_d   = '0;
            dirty_d = 1'b0;
            state_d = BK_SCAN;
          end else if (out_free) begin
            q_pop_o     = 1'b1;
            out_valid_d = 1'b1;
            out_d       = '0;
            out_d.last_item = 1'b1;
            unique case (q_head_i.cmd)
              CMD_FLASH: begin
                out_d.tiles        = q_head_i.mask;
                out_d.show_flash   = 1'b1;
                out_d.color        = q_head_i.color;
                out_d.show_request = 1'b1;
                if (free_found) begin
                  // claim the slot and start in the flash phase
                  out_d.kind           = KIND_RENDER;
                  out_d.slot           = SLOT_W'(free_idx);
                  active_d[free_idx]   = 1'b1;
                  tiles_d[free_idx]    = q_head_i.mask;
                  color_d[free_idx]    = q_head_i.color;
                  halves_d[free_idx]   = q_head_i.halves;
                  phase_d[free_idx]    = 1'b1;
                  interval_d[free_idx] = q_head_i.interval;
                  next_d[free_idx]     = q_head_i.now_ms + TIME_W'(q_head_i.interval);
                end else begin
                  out_d.kind = KIND_PAINT;
                end
              end
              CMD_CANCEL: begin
                out_d.kind = KIND_CANCEL;
                active_d   = '0;
              end
              default: begin
                out_d.kind = KIND_IGNORE;
              end
            endcase
          end
        end
      end

      BK_SCAN: begin
        // one slot per cycle, waiting on the output only for due slots
        if (!due || out_free) begin
          if (due) begin
            dirty_d            = 1'b1;
            halves_d[idx_q]    = halves_dec;
            out_valid_d        = 1'b1;
            out_d              = '0;
            out_d.kind         = KIND_RENDER;
            out_d.slot         = SLOT_W'(idx_q);
            out_d.tiles        = tiles_q[idx_q];
            out_d.color        = color_q[idx_q];
            out_d.show_request = 1'b1;
            if (halves_dec == '0) begin
              // job ran out: restore base colour and retire
              phase_d[idx_q]  = 1'b0;
              active_d[idx_q] = 1'b0;
              out_d.job_done  = 1'b1;
            end else begin
              phase_d[idx_q]   = !phase_q[idx_q];
              out_d.show_flash = !phase_q[idx_q];
              next_d[idx_q]    = now_q + TIME_W'(interval_q[idx_q]);
            end
          end
          if (last_slot) begin
            state_d = BK_SUMMARY;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end

      BK_SUMMARY: begin
        // tick summary with refresh check
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d           = '0;
          out_d.kind      = KIND_TICK;
          out_d.last_item = 1'b1;
          if (dirty_q || ((active_q == '0) && (idle_time >= TIME_W'(refresh_ivl_q)))) begin
            out_d.show_request = 1'b1;
            last_refresh_d     = now_q;
          end
          state_d = BK_IDLE;
        end
      end

      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= BK_IDLE;
      active_q       <= '0;
      out_valid_q    <= 1'b0;
      last_refresh_q <= '0;
      refresh_ivl_q  <= REFRESH_RESET;
    end else begin
      state_q        <= state_d;
      active_q       <= active_d;
      out_valid_q    <= out_valid_d;
      last_refresh_q <= last_refresh_d;
      if (cfg_we_i) begin
        refresh_ivl_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tiles_q    <= tiles_d;
    color_q    <= color_d;
    halves_q   <= halves_d;
    phase_q    <= phase_d;
    interval_q <= interval_d;
    next_q     <= next_d;
    idx_q      <= idx_d;
    now_q      <= now_d;
    dirty_q    <= dirty_d;
    out_q      <= out_d;
  end

endmodule

`default_nettype wire
